// File: sv/mrbf_pkg.sv
`timescale 1ns / 1ps

package mrbf_pkg;

  localparam int FUNC_W       = 1;
  localparam int READER_ID_W  = 3;
  localparam int DATA_FIELD_W = 64;
  localparam int STATUS_W     = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NODATA = 2'd1,
    ST_FAIL   = 2'd2
  } status_t;

  typedef struct packed {
    logic capture;  // latch the incoming word
    logic commit;   // decide, update pointers, access the record store
    logic finish;   // load the result register
  } cmd_t;

endpackage

// File: sv/mrbf_ctrl.sv
`timescale 1ns / 1ps

module mrbf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output mrbf_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.commit  = (state_r == S_EXEC) && out_free;
    cmd.finish  = (state_r == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          // result slot must be free before anything is committed
          if (out_free) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/mrbf_dp.sv
`timescale 1ns / 1ps

module mrbf_dp #(
  parameter int DEPTH        = 16,
  parameter int READER_COUNT = 2,
  parameter int DATA_W       = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mrbf_pkg::cmd_t                      cmd,
  input  logic [mrbf_pkg::FUNC_W-1:0]         func,
  input  logic [mrbf_pkg::READER_ID_W-1:0]    reader_id,
  input  logic [DATA_W-1:0]                   data_in,
  output logic [mrbf_pkg::STATUS_W-1:0]       status,
  output logic [DATA_W-1:0]                   data_out
);

  localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int RIW = mrbf_pkg::READER_ID_W;
  localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(DEPTH - 1);
  localparam logic [RIW:0]  READERS_X = (RIW + 1)'(READER_COUNT);

  // record store: written and read only at valid entries
  logic [DATA_W-1:0] mem [DEPTH];

  logic [mrbf_pkg::FUNC_W-1:0] func_r;
  logic [RIW-1:0]              rid_r;
  logic [DATA_W-1:0]           din_r;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  // per reader: how many entries from the head this reader has already taken
  logic [CW-1:0] rd_cnt_r   [READER_COUNT];
  logic [CW-1:0] rd_cnt_nxt [READER_COUNT];

  mrbf_pkg::status_t st_r, st_c;
  logic              rd_ok_r;
  logic [DATA_W-1:0] rdata_r;
  logic [mrbf_pkg::STATUS_W-1:0] out_status_r;
  logic [DATA_W-1:0]             out_data_r;

  logic [CW-1:0] rc;
  logic          others_read;
  logic          bad_id;
  logic          ins_ok;
  logic          rm_ok;
  logic          retire;
  logic [IW:0]   pos_sum;
  logic [IW-1:0] pos;

  always_comb begin
    rc          = '0;
    others_read = 1'b1;
    for (int i = 0; i < READER_COUNT; i++) begin
      if (rid_r == RIW'(i)) begin
        rc = rd_cnt_r[i];
      end else if (rd_cnt_r[i] == '0) begin
        others_read = 1'b0;
      end
    end
  end

  assign bad_id = ({1'b0, rid_r} >= READERS_X);

  always_comb begin
    pos_sum = (IW + 1)'(head_r) + (IW + 1)'(rc);
    if (pos_sum >= DEPTH_X) begin
      pos_sum = pos_sum - DEPTH_X;
    end
    pos = pos_sum[IW-1:0];
  end

  always_comb begin
    st_c   = mrbf_pkg::ST_OK;
    ins_ok = 1'b0;
    rm_ok  = 1'b0;
    if (func_r == mrbf_pkg::FUNC_INSERT) begin
      if (cnt_r == DEPTH_C) begin
        st_c = mrbf_pkg::ST_FAIL;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (bad_id) begin
      st_c = mrbf_pkg::ST_FAIL;
    end else if (rc >= cnt_r) begin
      st_c = mrbf_pkg::ST_NODATA;
    end else begin
      rm_ok = 1'b1;
    end
  end

  // head goes once the last reader takes it
  assign retire = rm_ok && (rc == '0) && others_read;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    for (int i = 0; i < READER_COUNT; i++) begin
      rd_cnt_nxt[i] = rd_cnt_r[i];
    end
    if (cmd.commit) begin
      if (ins_ok) begin
        tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + IW'(1);
        cnt_nxt  = cnt_r + CW'(1);
      end
      if (rm_ok) begin
        for (int i = 0; i < READER_COUNT; i++) begin
          if (rid_r == RIW'(i)) begin
            rd_cnt_nxt[i] = rd_cnt_nxt[i] + CW'(1);
          end
          if (retire) begin
            rd_cnt_nxt[i] = rd_cnt_nxt[i] - CW'(1);
          end
        end
        if (retire) begin
          head_nxt = (head_r == LAST_IDX) ? '0 : head_r + IW'(1);
          cnt_nxt  = cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
      for (int i = 0; i < READER_COUNT; i++) begin
        rd_cnt_r[i] <= '0;
      end
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      for (int i = 0; i < READER_COUNT; i++) begin
        rd_cnt_r[i] <= rd_cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= func;
      rid_r  <= reader_id;
      din_r  <= data_in;
    end
    if (cmd.commit) begin
      st_r    <= st_c;
      rd_ok_r <= rm_ok;
    end
    if (cmd.finish) begin
      out_status_r <= st_r;
      out_data_r   <= rd_ok_r ? rdata_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && ins_ok) begin
      mem[tail_r] <= din_r;
    end
    if (cmd.commit && rm_ok) begin
      rdata_r <= mem[pos];
    end
  end

  assign status   = out_status_r;
  assign data_out = out_data_r;

endmodule

// File: sv/multi_reader_broadcast_fifo_unit.sv
`timescale 1ns / 1ps

// Broadcast FIFO of DEPTH records shared by READER_COUNT readers; every reader
// gets every record once, in insertion order. func 0 appends data_in (status 2
// when full); func 1 returns the oldest record this reader has not yet taken
// (status 1 if none, status 2 for a reader id at or above READER_COUNT). The
// head record is freed once the last reader takes it. One word is accepted at
// a time and goes from accept to result through capture, decision plus record
// store access (one synchronous RAM port), and the result register load. A
// result left waiting on out_stall holds the next word in its decision step.
// Reset needs no clearing pass.
module multi_reader_broadcast_fifo_unit #(
  parameter int DEPTH        = 16,
  parameter int READER_COUNT = 2,
  parameter int DATA_W       = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [0:0]  in_func,
  input  logic [2:0]  in_reader_id,
  input  logic [63:0] in_data_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [63:0] out_data_out
);

  localparam int OUT_W = mrbf_pkg::DATA_FIELD_W;

  mrbf_pkg::cmd_t    cmd;
  logic [DATA_W-1:0] dout;

  mrbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  mrbf_dp #(
    .DEPTH        (DEPTH),
    .READER_COUNT (READER_COUNT),
    .DATA_W       (DATA_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .func      (in_func),
    .reader_id (in_reader_id),
    .data_in   (in_data_in[DATA_W-1:0]),
    .status    (out_status),
    .data_out  (dout)
  );

  assign out_data_out = OUT_W'(dout);

endmodule
